// ===== sv/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame sequence timer package
// Shared constants for the frame sequence timer and its checker.
// ----------------------------------------------------------------------------
package fst_pkg;

  // Default table depth and walk cap.
  localparam int unsigned FRAMES_DEF     = 64;
  localparam int unsigned WALK_LIMIT_DEF = 64;

  // Field widths.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned TILE_W  = 16;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned REM_W   = 26;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

endpackage

// ===== sv/frame_sequence_timer.sv =====
// ----------------------------------------------------------------------------
// Frame sequence timer
// Steps an animation through a table of frames as tick time passes.
// ----------------------------------------------------------------------------
// Each input beat yields one result beat. The block works on one item at a
// time. Append, restart and no-op items, and a tick on an empty table, pass
// through the execute, tile and output states. A tick on a non-empty table
// also passes the check state, and the add and check states again for each
// frame advanced (at most WALK_LIMIT). Every advance needs a frame table read,
// then one pass through the shared remaining-time adder. The result register
// frees the input side, so a result waiting on out_stall_i does not hold back
// the next item until that item's own result is ready.
module frame_sequence_timer #(
  parameter int unsigned FRAMES     = fst_pkg::FRAMES_DEF,
  parameter int unsigned WALK_LIMIT = fst_pkg::WALK_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fst_pkg::OP_W-1:0]     opcode_i,
  input  logic [fst_pkg::TIME_W-1:0]   elapsed_i,
  input  logic [fst_pkg::TIME_W-1:0]   frame_duration_i,
  input  logic [fst_pkg::TILE_W-1:0]   tile_id_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         frame_changed_o,
  output logic [fst_pkg::FRAME_W-1:0]  current_frame_o,
  output logic [fst_pkg::TILE_W-1:0]   current_tile_o,
  output logic                         finished_o,
  output logic                         has_frames_o,
  output logic                         dropped_o
);

  localparam int unsigned IW    = $clog2(FRAMES);
  localparam int unsigned CW    = $clog2(FRAMES + 1);
  localparam int unsigned SW    = $clog2(WALK_LIMIT + 1);
  localparam int unsigned TW    = fst_pkg::TIME_W;
  localparam int unsigned LW    = fst_pkg::TILE_W;
  localparam int unsigned RW    = fst_pkg::REM_W;
  localparam int unsigned MW    = LW + TW;
  localparam int unsigned FW    = fst_pkg::FRAME_W;

  localparam logic [CW-1:0] FRAMES_C = CW'(FRAMES);
  localparam logic [SW-1:0] LIMIT_C  = SW'(WALK_LIMIT);
  localparam logic [RW-1:0] REM_MIN  = {1'b1, {(RW-1){1'b0}}};

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_TILE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic                      loop_q;
  logic [CW-1:0]             count_q, count_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic [IW-1:0]             prev_q, prev_d;
  logic [RW-1:0]             rem_q, rem_d;
  logic [SW-1:0]             steps_q, steps_d;
  logic                      stopped_q, stopped_d;
  logic                      dropped_q, dropped_d;

  logic [fst_pkg::OP_W-1:0]  op_q;
  logic [TW-1:0]             elapsed_q;
  logic [TW-1:0]             dur_q;
  logic [LW-1:0]             tile_q;

  logic [MW-1:0]             mem [FRAMES];
  logic [MW-1:0]             rdata_q;
  logic [IW-1:0]             raddr;
  logic                      mem_we;

  logic [CW-1:0]             idx_ext;
  logic [CW-1:0]             idx_inc;
  logic                      is_last;
  logic [IW-1:0]             nxt_idx;
  logic [RW:0]               opnd;
  logic [RW:0]               sum;
  logic [RW-1:0]             sum_sat;
  logic                      out_free;
  logic                      finished;
  logic [IW+FW-1:0]          frame_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;

  assign idx_ext = CW'(idx_q);
  assign idx_inc = idx_ext + CW'(1);
  assign is_last = (idx_inc >= count_q);
  assign nxt_idx = is_last ? '0 : idx_inc[IW-1:0];

  // The one adder serves both the elapsed-time subtract and the dwell add.
  // A result that does not fit the remaining-time width can only be a deficit
  // below the floor, so it saturates there.
  assign opnd    = (state_q == S_ADD) ? (RW+1)'(rdata_q[TW-1:0])
                                      : -((RW+1)'(elapsed_q));
  assign sum     = {rem_q[RW-1], rem_q} + opnd;
  assign sum_sat = (sum[RW] != sum[RW-1]) ? REM_MIN : sum[RW-1:0];

  assign finished   = !loop_q && rem_q[RW-1] && is_last;
  assign frame_wide = {{FW{1'b0}}, idx_q};

  assign raddr  = (state_q == S_CHK) ? nxt_idx : idx_q;
  assign mem_we = (state_q == S_EXEC) && (op_q == fst_pkg::OP_APPEND) &&
                  (count_q < FRAMES_C);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= {tile_q, dur_q};
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    rem_d     = rem_q;
    steps_d   = steps_q;
    stopped_d = stopped_q;
    dropped_d = dropped_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          stopped_d = 1'b0;
          dropped_d = 1'b0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_TILE;
        case (op_q)
          fst_pkg::OP_TICK: begin
            if (count_q != '0) begin
              rem_d   = sum_sat;
              prev_d  = idx_q;
              steps_d = '0;
              state_d = S_CHK;
            end
          end
          fst_pkg::OP_APPEND: begin
            if (count_q >= FRAMES_C) begin
              dropped_d = 1'b1;
            end else begin
              if (count_q == '0) begin
                rem_d = RW'(dur_q);
                idx_d = '0;
              end
              count_d = count_q + CW'(1);
            end
          end
          fst_pkg::OP_RESTART: begin
            idx_d = '0;
            rem_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_CHK: begin
        if (rem_q[RW-1] && (steps_q < LIMIT_C)) begin
          if (is_last && !loop_q) begin
            stopped_d = 1'b1;
            state_d   = S_TILE;
          end else begin
            state_d = S_ADD;
          end
        end else begin
          state_d = S_TILE;
        end
      end
      S_ADD: begin
        // The table read for the next frame was issued in the check state.
        rem_d   = sum[RW-1:0];
        idx_d   = nxt_idx;
        steps_d = steps_q + SW'(1);
        state_d = S_CHK;
      end
      S_TILE: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      loop_q    <= 1'b1;
      count_q   <= '0;
      idx_q     <= '0;
      prev_q    <= '0;
      rem_q     <= '0;
      steps_q   <= '0;
      stopped_q <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      prev_q    <= prev_d;
      rem_q     <= rem_d;
      steps_q   <= steps_d;
      stopped_q <= stopped_d;
      dropped_q <= dropped_d;
      if (cfg_we_i) begin
        loop_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      op_q      <= opcode_i;
      elapsed_q <= elapsed_i;
      dur_q     <= frame_duration_i;
      tile_q    <= tile_id_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      frame_changed_o <= (op_q == fst_pkg::OP_TICK) && !stopped_q && (prev_q != idx_q) &&
                         (count_q != '0);
      current_frame_o <= frame_wide[FW-1:0];
      current_tile_o  <= (count_q != '0) ? rdata_q[MW-1:TW] : '0;
      finished_o      <= finished;
      has_frames_o    <= (count_q != '0);
      dropped_o       <= dropped_q;
    end
  end

endmodule

// ===== sv/fst_checker.sv =====
// ----------------------------------------------------------------------------
// Frame sequence timer checker
// Port-level checks on the frame sequence timer, attached by bind.
// ----------------------------------------------------------------------------
module fst_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         frame_changed_o,
  input logic [fst_pkg::FRAME_W-1:0]  current_frame_o,
  input logic [fst_pkg::TILE_W-1:0]   current_tile_o,
  input logic                         finished_o,
  input logic                         has_frames_o,
  input logic                         dropped_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(current_frame_o) &&
    $stable(current_tile_o) && $stable(frame_changed_o))
  else $error("stalled result beat changed");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("input accepted while an item is in progress");

  // An empty table shows no tile, no change and no finish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_frames_o |-> current_tile_o == '0 && !frame_changed_o &&
    !finished_o && current_frame_o == '0)
  else $error("empty table reported frame state");

  // A refused append only happens on a full table and never moves the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> has_frames_o && !frame_changed_o)
  else $error("dropped append with bad status");

endmodule

bind frame_sequence_timer fst_checker u_fst_checker (.*);
